/* hw/rtl/nalr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// NAL-R band gain prescriber package
// Field widths, fixed-point coefficients, pipeline sizing and shared types.
// ----------------------------------------------------------------------------
package nalr_pkg;

    // Port field widths.
    localparam int FREQ_W  = 15;
    localparam int THR_W   = 8;
    localparam int UCL_W   = 8;
    localparam int RANGE_W = 9;
    localparam int GAIN_W  = 10;
    localparam int RATIO_W = 10;
    localparam int MPO_W   = 7;

    // Internal widths.
    localparam int SUM_W     = 16;          // 13*avg + 79*thr in 1/256 dB
    localparam int ADD_W     = 14;          // 38*thr in 1/256 dB
    localparam int MED_W     = 12;          // signed medium gain before clamp
    localparam int K_W       = 6;           // frequency correction in dB
    localparam int ADD_LIM_W = 8;           // clamped soft/loud adjustment
    localparam int SOFT_W    = GAIN_W + 1;
    localparam int LOUD_W    = GAIN_W + 2;

    // Divider sizing: quotient bits retired per stage and number of stages.
    localparam int DIV_STAGES = 5;
    localparam int STEP_BITS  = 3;
    localparam int QUO_W      = DIV_STAGES * STEP_BITS;
    localparam int DVS_W      = RANGE_W - 1;

    // Coefficients in 1/256 and limits.
    localparam int COEF_AVG     = 13;
    localparam int COEF_THR     = 79;
    localparam int COEF_ADD     = 38;
    localparam int ROUND_HALF   = 8;
    localparam int GAIN_MAX     = 1023;
    localparam int SOFT_ADD_MAX = 96;
    localparam int LOUD_ADD_MAX = 128;
    localparam int CR_NUMER     = 16640;    // 65 dB in Q8
    localparam int RATIO_MIN    = 256;
    localparam int RATIO_MAX    = 896;
    localparam int MPO_MIN      = 80;
    localparam int MPO_MAX      = 105;

    typedef enum logic [1:0] {
        RS_POS,
        RS_ZERO,
        RS_NEG
    } t_range_sel;

    // Restoring divider state carried from stage to stage.
    typedef struct packed {
        logic [DVS_W-1:0] rem;
        logic [QUO_W-1:0] num;
        logic [QUO_W-1:0] quo;
        logic [DVS_W-1:0] dvs;
    } t_div;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic signed [ADD_W-1:0] add;
        logic signed [K_W-1:0]   k;
        logic [MPO_W-1:0]        mpo;
        t_range_sel              sel;
        t_div                    dv;
    } t_prep;

    typedef struct packed {
        t_div              dv;
        t_range_sel        sel;
        logic [GAIN_W-1:0] med_gain;
        logic [GAIN_W-1:0] soft_gain;
        logic [GAIN_W-1:0] loud;
        logic [MPO_W-1:0]  mpo;
    } t_stage;

    // Stepped NAL-R frequency correction in whole dB.
    function automatic logic signed [K_W-1:0] corr_k(input logic [FREQ_W-1:0] f);
        logic signed [K_W-1:0] k;
        if (f <= FREQ_W'(125)) begin
            k = -K_W'(20);
        end else if (f <= FREQ_W'(250)) begin
            k = -K_W'(17);
        end else if (f <= FREQ_W'(500)) begin
            k = -K_W'(8);
        end else if (f <= FREQ_W'(750)) begin
            k = -K_W'(3);
        end else if (f <= FREQ_W'(1000)) begin
            k = K_W'(1);
        end else if (f <= FREQ_W'(2000)) begin
            k = -K_W'(1);
        end else if (f <= FREQ_W'(4000)) begin
            k = -K_W'(2);
        end else if (f <= FREQ_W'(6000)) begin
            k = -K_W'(3);
        end else begin
            k = -K_W'(4);
        end
        return k;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/nal_r_band_gain_prescriber.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// NAL-R band gain prescriber
// Per-band medium/soft/loud gains, compression ratio and output limit.
// ----------------------------------------------------------------------------
// One band item is taken in every clock cycle; busy is held low and never
// refuses an item. Each result appears on the o_ ports with o_valid high for
// a single cycle, in input order, once it has passed the preparation register,
// the five divider stages and the output register. The pipeline depth is set
// by the compression-ratio divider: a restoring divider of five register
// stages that retires three quotient bits per stage, with one preparation
// stage in front and the output register behind it. Gains and the output limit
// are finished early and ride along with the divider. There is no state
// between items, so the receiver must take each result when shown.
module nal_r_band_gain_prescriber (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      start,
    output logic                                     busy,
    input  wire        [nalr_pkg::FREQ_W-1:0]        i_frequency_hz,
    input  wire signed [nalr_pkg::THR_W-1:0]         i_hearing_threshold_db,
    input  wire signed [nalr_pkg::THR_W-1:0]         i_three_freq_average_db,
    input  wire        [nalr_pkg::UCL_W-1:0]         i_discomfort_level_db,
    input  wire signed [nalr_pkg::RANGE_W-1:0]       i_dynamic_range_db,
    output logic                                     o_valid,
    output logic       [nalr_pkg::GAIN_W-1:0]        o_medium_gain,
    output logic       [nalr_pkg::GAIN_W-1:0]        o_soft_gain,
    output logic       [nalr_pkg::GAIN_W-1:0]        o_loud_gain,
    output logic       [nalr_pkg::RATIO_W-1:0]       o_compression_ratio,
    output logic       [nalr_pkg::MPO_W-1:0]         o_max_output_db
);

    localparam int LATENCY = nalr_pkg::DIV_STAGES + 2;

    logic                 accept;

    nalr_pkg::t_prep      r_prep, n_prep;
    logic                 r_prep_vld;

    nalr_pkg::t_stage     r_st [1:nalr_pkg::DIV_STAGES];
    nalr_pkg::t_stage     n_st [1:nalr_pkg::DIV_STAGES];
    logic [nalr_pkg::DIV_STAGES:1] r_st_vld;

    logic                                r_out_vld;
    logic [nalr_pkg::GAIN_W-1:0]         r_out_medium, r_out_soft, r_out_loud;
    logic [nalr_pkg::RATIO_W-1:0]        r_out_ratio, n_out_ratio;
    logic [nalr_pkg::MPO_W-1:0]          r_out_mpo;

    // Gains computed in the first divider stage.
    logic [nalr_pkg::GAIN_W-1:0] n_medium, n_soft, n_loud;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Preparation stage: constant products, correction, limits, numerator.
    // ------------------------------------------------------------------
    always_comb begin
        n_prep.sum = nalr_pkg::SUM_W'(nalr_pkg::COEF_AVG * i_three_freq_average_db
                                    + nalr_pkg::COEF_THR * i_hearing_threshold_db);
        n_prep.add = nalr_pkg::ADD_W'(nalr_pkg::COEF_ADD * i_hearing_threshold_db);
        n_prep.k   = nalr_pkg::corr_k(i_frequency_hz);

        if (i_discomfort_level_db < nalr_pkg::UCL_W'(nalr_pkg::MPO_MIN)) begin
            n_prep.mpo = nalr_pkg::MPO_W'(nalr_pkg::MPO_MIN);
        end else if (i_discomfort_level_db > nalr_pkg::UCL_W'(nalr_pkg::MPO_MAX)) begin
            n_prep.mpo = nalr_pkg::MPO_W'(nalr_pkg::MPO_MAX);
        end else begin
            n_prep.mpo = i_discomfort_level_db[nalr_pkg::MPO_W-1:0];
        end

        if (i_dynamic_range_db == '0) begin
            n_prep.sel = nalr_pkg::RS_ZERO;
        end else if (i_dynamic_range_db[nalr_pkg::RANGE_W-1]) begin
            n_prep.sel = nalr_pkg::RS_NEG;
        end else begin
            n_prep.sel = nalr_pkg::RS_POS;
        end

        // Numerator adds half the divisor so the quotient rounds to nearest.
        n_prep.dv.num = nalr_pkg::QUO_W'(nalr_pkg::CR_NUMER)
                      + nalr_pkg::QUO_W'(i_dynamic_range_db[nalr_pkg::DVS_W-1:1]);
        n_prep.dv.dvs = i_dynamic_range_db[nalr_pkg::DVS_W-1:0];
        n_prep.dv.rem = '0;
        n_prep.dv.quo = '0;
    end

    // ------------------------------------------------------------------
    // Gain finishing, from the preparation register.
    // ------------------------------------------------------------------
    always_comb begin
        logic signed [nalr_pkg::SUM_W-1:0]  sum_r;
        logic signed [nalr_pkg::ADD_W-1:0]  add_r;
        logic signed [nalr_pkg::MED_W-1:0]  med;
        logic [nalr_pkg::ADD_LIM_W-1:0]     add_s, add_l;
        logic [nalr_pkg::SOFT_W-1:0]        soft_w;
        logic signed [nalr_pkg::LOUD_W-1:0] loud_w;

        // Arithmetic shift floors, which rounds half up after the bias.
        sum_r = (r_prep.sum + nalr_pkg::SUM_W'(nalr_pkg::ROUND_HALF)) >>> 4;
        add_r = (r_prep.add + nalr_pkg::ADD_W'(nalr_pkg::ROUND_HALF)) >>> 4;
        med   = nalr_pkg::MED_W'(sum_r) + (nalr_pkg::MED_W'(r_prep.k) <<< 4);

        if (med < 0) begin
            n_medium = '0;
        end else if (med > nalr_pkg::GAIN_MAX) begin
            n_medium = nalr_pkg::GAIN_W'(nalr_pkg::GAIN_MAX);
        end else begin
            n_medium = med[nalr_pkg::GAIN_W-1:0];
        end

        if (add_r < 0) begin
            add_s = '0;
            add_l = '0;
        end else begin
            if (add_r > nalr_pkg::SOFT_ADD_MAX) begin
                add_s = nalr_pkg::ADD_LIM_W'(nalr_pkg::SOFT_ADD_MAX);
            end else begin
                add_s = add_r[nalr_pkg::ADD_LIM_W-1:0];
            end
            if (add_r > nalr_pkg::LOUD_ADD_MAX) begin
                add_l = nalr_pkg::ADD_LIM_W'(nalr_pkg::LOUD_ADD_MAX);
            end else begin
                add_l = add_r[nalr_pkg::ADD_LIM_W-1:0];
            end
        end

        soft_w = {1'b0, n_medium} + nalr_pkg::SOFT_W'(add_s);
        if (soft_w > nalr_pkg::SOFT_W'(nalr_pkg::GAIN_MAX)) begin
            n_soft = nalr_pkg::GAIN_W'(nalr_pkg::GAIN_MAX);
        end else begin
            n_soft = soft_w[nalr_pkg::GAIN_W-1:0];
        end

        loud_w = $signed({2'b00, n_medium}) - $signed(nalr_pkg::LOUD_W'(add_l));
        if (loud_w < 0) begin
            n_loud = '0;
        end else begin
            n_loud = loud_w[nalr_pkg::GAIN_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: each retires STEP_BITS quotient bits.
    // ------------------------------------------------------------------
    always_comb begin
        nalr_pkg::t_div         cur;
        logic [nalr_pkg::DVS_W:0] trial;

        for (int s = 1; s <= nalr_pkg::DIV_STAGES; s++) begin
            if (s == 1) begin
                cur               = r_prep.dv;
                n_st[s].sel       = r_prep.sel;
                n_st[s].med_gain  = n_medium;
                n_st[s].soft_gain = n_soft;
                n_st[s].loud      = n_loud;
                n_st[s].mpo       = r_prep.mpo;
            end else begin
                cur               = r_st[s-1].dv;
                n_st[s].sel       = r_st[s-1].sel;
                n_st[s].med_gain  = r_st[s-1].med_gain;
                n_st[s].soft_gain = r_st[s-1].soft_gain;
                n_st[s].loud      = r_st[s-1].loud;
                n_st[s].mpo       = r_st[s-1].mpo;
            end

            for (int j = 0; j < nalr_pkg::STEP_BITS; j++) begin
                trial   = {cur.rem, cur.num[nalr_pkg::QUO_W-1]};
                cur.num = {cur.num[nalr_pkg::QUO_W-2:0], 1'b0};
                if (trial >= {1'b0, cur.dvs}) begin
                    trial   = trial - {1'b0, cur.dvs};
                    cur.quo = {cur.quo[nalr_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    cur.quo = {cur.quo[nalr_pkg::QUO_W-2:0], 1'b0};
                end
                cur.rem = trial[nalr_pkg::DVS_W-1:0];
            end
            n_st[s].dv = cur;
        end
    end

    // ------------------------------------------------------------------
    // Ratio selection and clamp for the output register.
    // ------------------------------------------------------------------
    always_comb begin
        logic [nalr_pkg::QUO_W-1:0] q;
        q = r_st[nalr_pkg::DIV_STAGES].dv.quo;
        case (r_st[nalr_pkg::DIV_STAGES].sel)
            nalr_pkg::RS_ZERO: n_out_ratio = nalr_pkg::RATIO_W'(nalr_pkg::RATIO_MAX);
            nalr_pkg::RS_NEG:  n_out_ratio = nalr_pkg::RATIO_W'(nalr_pkg::RATIO_MIN);
            nalr_pkg::RS_POS: begin
                if (q < nalr_pkg::QUO_W'(nalr_pkg::RATIO_MIN)) begin
                    n_out_ratio = nalr_pkg::RATIO_W'(nalr_pkg::RATIO_MIN);
                end else if (q > nalr_pkg::QUO_W'(nalr_pkg::RATIO_MAX)) begin
                    n_out_ratio = nalr_pkg::RATIO_W'(nalr_pkg::RATIO_MAX);
                end else begin
                    n_out_ratio = q[nalr_pkg::RATIO_W-1:0];
                end
            end
            default: n_out_ratio = nalr_pkg::RATIO_W'(nalr_pkg::RATIO_MIN);
        endcase
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_vld <= 1'b0;
            r_st_vld   <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_prep_vld <= accept;
            r_st_vld   <= {r_st_vld[nalr_pkg::DIV_STAGES-1:1], r_prep_vld};
            r_out_vld  <= r_st_vld[nalr_pkg::DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prep <= n_prep;
        for (int s = 1; s <= nalr_pkg::DIV_STAGES; s++) begin
            r_st[s] <= n_st[s];
        end
        r_out_medium <= r_st[nalr_pkg::DIV_STAGES].med_gain;
        r_out_soft   <= r_st[nalr_pkg::DIV_STAGES].soft_gain;
        r_out_loud   <= r_st[nalr_pkg::DIV_STAGES].loud;
        r_out_mpo    <= r_st[nalr_pkg::DIV_STAGES].mpo;
        r_out_ratio  <= n_out_ratio;
    end

    assign o_valid             = r_out_vld;
    assign o_medium_gain       = r_out_medium;
    assign o_soft_gain         = r_out_soft;
    assign o_loud_gain         = r_out_loud;
    assign o_compression_ratio = r_out_ratio;
    assign o_max_output_db     = r_out_mpo;

`ifndef ASSERT_OFF
    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_compression_ratio >= nalr_pkg::RATIO_W'(nalr_pkg::RATIO_MIN)
                  && o_compression_ratio <= nalr_pkg::RATIO_W'(nalr_pkg::RATIO_MAX)))
        else $error("compression ratio out of range");

    a_gain_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_soft_gain >= o_medium_gain && o_loud_gain <= o_medium_gain))
        else $error("soft/loud gains not ordered around medium gain");

    a_zero_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_dynamic_range_db == '0) |-> ##LATENCY
            (o_valid && o_compression_ratio == nalr_pkg::RATIO_W'(nalr_pkg::RATIO_MAX)))
        else $error("zero dynamic range item did not give the maximum ratio");

    a_mpo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_max_output_db >= nalr_pkg::MPO_W'(nalr_pkg::MPO_MIN)
                  && o_max_output_db <= nalr_pkg::MPO_W'(nalr_pkg::MPO_MAX)))
        else $error("output limit out of range");
`endif

endmodule
`default_nettype wire

/* verif/nal_r_band_gain_prescriber_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// NAL-R band gain prescriber testbench
// Drives directed and random band items through the command handshake, with
// random bursts of sender idling, and checks every result field against a
// local prescription calculator, in order.
// ----------------------------------------------------------------------------
module nal_r_band_gain_prescriber_tb;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_ITEMS = 1850;
    localparam int CALM_TAIL    = 200;    // last random items sent back to back
    localparam int DRAIN_CYCLES = 24;
    localparam int STALL_LIMIT  = 256;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        logic [nalr_pkg::FREQ_W-1:0]         freq;
        logic signed [nalr_pkg::THR_W-1:0]   thr;
        logic signed [nalr_pkg::THR_W-1:0]   avg;
        logic [nalr_pkg::UCL_W-1:0]          ucl;
        logic signed [nalr_pkg::RANGE_W-1:0] rng;
    } t_band;

    typedef struct packed {
        logic [nalr_pkg::GAIN_W-1:0]  med_gain;
        logic [nalr_pkg::GAIN_W-1:0]  soft_gain;
        logic [nalr_pkg::GAIN_W-1:0]  loud;
        logic [nalr_pkg::RATIO_W-1:0] ratio;
        logic [nalr_pkg::MPO_W-1:0]   mpo;
    } t_prescription;

    typedef struct {
        t_band band;
        int    gap;
    } t_pending_band;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    logic        [nalr_pkg::FREQ_W-1:0]  i_frequency_hz          = '0;
    logic signed [nalr_pkg::THR_W-1:0]   i_hearing_threshold_db  = '0;
    logic signed [nalr_pkg::THR_W-1:0]   i_three_freq_average_db = '0;
    logic        [nalr_pkg::UCL_W-1:0]   i_discomfort_level_db   = '0;
    logic signed [nalr_pkg::RANGE_W-1:0] i_dynamic_range_db      = '0;
    logic                                o_valid;
    logic        [nalr_pkg::GAIN_W-1:0]  o_medium_gain;
    logic        [nalr_pkg::GAIN_W-1:0]  o_soft_gain;
    logic        [nalr_pkg::GAIN_W-1:0]  o_loud_gain;
    logic        [nalr_pkg::RATIO_W-1:0] o_compression_ratio;
    logic        [nalr_pkg::MPO_W-1:0]   o_max_output_db;

    t_pending_band band_q[$];
    t_prescription prescription_q[$];
    t_pending_band next_band;
    t_band         shown_band;
    bit            have_next = 1'b0;
    int            idle_left = 0;
    int            bands_total = 0;
    int            bands_sent = 0;
    int            mismatch_cnt = 0;
    int            stall_cnt = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    nal_r_band_gain_prescriber u_dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .start                   (start),
        .busy                    (busy),
        .i_frequency_hz          (i_frequency_hz),
        .i_hearing_threshold_db  (i_hearing_threshold_db),
        .i_three_freq_average_db (i_three_freq_average_db),
        .i_discomfort_level_db   (i_discomfort_level_db),
        .i_dynamic_range_db      (i_dynamic_range_db),
        .o_valid                 (o_valid),
        .o_medium_gain           (o_medium_gain),
        .o_soft_gain             (o_soft_gain),
        .o_loud_gain             (o_loud_gain),
        .o_compression_ratio     (o_compression_ratio),
        .o_max_output_db         (o_max_output_db)
    );

    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Takes a value in 1/256 dB to 1/16 dB, rounding half up.
    function automatic int to_sixteenths(int x);
        return (x + nalr_pkg::ROUND_HALF) >>> 4;
    endfunction

    function automatic int band_correction_db(int unsigned f);
        if (f <= 125) begin
            return -20;
        end else if (f <= 250) begin
            return -17;
        end else if (f <= 500) begin
            return -8;
        end else if (f <= 750) begin
            return -3;
        end else if (f <= 1000) begin
            return 1;
        end else if (f <= 2000) begin
            return -1;
        end else if (f <= 4000) begin
            return -2;
        end else if (f <= 6000) begin
            return -3;
        end
        return -4;
    endfunction

    function automatic t_prescription prescribe_band(t_band b);
        int            thr;
        int            avg;
        int            rng;
        int            med;
        int            boost;
        int            ratio;
        int            soft_val;
        int            loud_val;
        t_prescription p;
        thr = $signed(b.thr);
        avg = $signed(b.avg);
        rng = $signed(b.rng);
        med = to_sixteenths(nalr_pkg::COEF_AVG * avg + nalr_pkg::COEF_THR * thr)
              + 16 * band_correction_db(b.freq);
        med = clamp_int(med, 0, nalr_pkg::GAIN_MAX);
        boost = to_sixteenths(nalr_pkg::COEF_ADD * thr);
        if (rng == 0) begin
            ratio = nalr_pkg::RATIO_MAX;
        end else if (rng < 0) begin
            ratio = nalr_pkg::RATIO_MIN;
        end else begin
            ratio = clamp_int((nalr_pkg::CR_NUMER + rng / 2) / rng,
                              nalr_pkg::RATIO_MIN, nalr_pkg::RATIO_MAX);
        end
        soft_val = clamp_int(med + clamp_int(boost, 0, nalr_pkg::SOFT_ADD_MAX),
                             0, nalr_pkg::GAIN_MAX);
        loud_val = clamp_int(med - clamp_int(boost, 0, nalr_pkg::LOUD_ADD_MAX),
                             0, nalr_pkg::GAIN_MAX);
        p.med_gain  = nalr_pkg::GAIN_W'(med);
        p.soft_gain = nalr_pkg::GAIN_W'(soft_val);
        p.loud      = nalr_pkg::GAIN_W'(loud_val);
        p.ratio     = nalr_pkg::RATIO_W'(ratio);
        p.mpo       = nalr_pkg::MPO_W'(clamp_int(int'(b.ucl), nalr_pkg::MPO_MIN,
                                                 nalr_pkg::MPO_MAX));
        return p;
    endfunction

    task automatic queue_band(int f, int thr, int avg, int ucl, int rng, int gap);
        t_pending_band pb;
        pb.band.freq = nalr_pkg::FREQ_W'(f);
        pb.band.thr  = nalr_pkg::THR_W'(thr);
        pb.band.avg  = nalr_pkg::THR_W'(avg);
        pb.band.ucl  = nalr_pkg::UCL_W'(ucl);
        pb.band.rng  = nalr_pkg::RANGE_W'(rng);
        pb.gap       = gap;
        band_q       = {band_q, pb};
        bands_total++;
    endtask

    task automatic flag_mismatch(string what, int got, int want);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_LIMIT) begin
            $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Driver: an item leaves the queue, waits out its idle gap, then holds start
    // until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                prescription_q = {prescription_q, prescribe_band(shown_band)};
                bands_sent++;
            end
            if (!start || !busy) begin
                if (!have_next && band_q.size() != 0) begin
                    next_band = band_q.pop_front();
                    have_next = 1'b1;
                    idle_left = next_band.gap;
                end
                if (have_next && idle_left == 0) begin
                    shown_band              = next_band.band;
                    have_next               = 1'b0;
                    start                   <= 1'b1;
                    i_frequency_hz          <= next_band.band.freq;
                    i_hearing_threshold_db  <= next_band.band.thr;
                    i_three_freq_average_db <= next_band.band.avg;
                    i_discomfort_level_db   <= next_band.band.ucl;
                    i_dynamic_range_db      <= next_band.band.rng;
                end else begin
                    start <= 1'b0;
                    if (idle_left != 0) begin
                        idle_left--;
                    end
                end
            end
        end
    end

    // Monitor: every strobed result is matched against the oldest prescription.
    always @(posedge i_clk) begin
        t_prescription want;
        if (i_rst_n && o_valid) begin
            if (prescription_q.size() == 0) begin
                flag_mismatch("unexpected result", o_medium_gain, 0);
            end else begin
                want = prescription_q.pop_front();
                if (o_medium_gain !== want.med_gain) begin
                    flag_mismatch("medium_gain", o_medium_gain, want.med_gain);
                end
                if (o_soft_gain !== want.soft_gain) begin
                    flag_mismatch("soft_gain", o_soft_gain, want.soft_gain);
                end
                if (o_loud_gain !== want.loud) begin
                    flag_mismatch("loud_gain", o_loud_gain, want.loud);
                end
                if (o_compression_ratio !== want.ratio) begin
                    flag_mismatch("compression_ratio", o_compression_ratio, want.ratio);
                end
                if (o_max_output_db !== want.mpo) begin
                    flag_mismatch("max_output_db", o_max_output_db, want.mpo);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid === 1'b1) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt + 1 >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        int unsigned freq_edges[8];
        int          f;
        int          thr;
        int          avg;
        int          ucl;
        int          rng;
        int          gap;
        bit          bursty;
        freq_edges = '{125, 250, 500, 750, 1000, 2000, 4000, 6000};

        // Field extremes, every correction step edge, the adjustment clamps,
        // zero and negative range, and ratio clamping at both ends.
        queue_band(0,     -128, -128, 0,   -256, 0);
        queue_band(32767, 127,  127,  255, 255,  0);
        queue_band(125,   -10,  -10,  79,  0,    3);
        queue_band(126,   120,  120,  80,  1,    0);
        queue_band(250,   0,    0,    105, -1,   0);
        queue_band(251,   40,   35,   106, 18,   0);
        queue_band(500,   41,   50,   140, 19,   1);
        queue_band(501,   53,   0,    100, 64,   0);
        queue_band(750,   54,   3,    90,  65,   0);
        queue_band(751,   55,   -1,   95,  66,   0);
        queue_band(1000,  25,   30,   110, 150,  0);
        queue_band(1001,  80,   70,   120, 100,  5);
        queue_band(2000,  100,  90,   130, 32,   0);
        queue_band(2001,  50,   60,   85,  47,   0);
        queue_band(4000,  70,   60,   96,  20,   0);
        queue_band(4001,  90,   100,  101, 10,   0);
        queue_band(6000,  110,  120,  104, 5,    0);
        queue_band(6001,  45,   40,   81,  2,    0);
        queue_band(24000, -5,   15,   200, -140, 0);
        queue_band(16384, 127,  -128, 128, 128,  0);
        queue_band(8191,  -128, 127,  127, -128, 0);

        bursty = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0) begin
                bursty = $urandom_range(0, 1);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: f = freq_edges[$urandom_range(0, 7)] + $urandom_range(0, 2) - 1;
                4, 5, 6, 7: f = $urandom_range(0, 24000);
                default:    f = $urandom_range(0, (1 << nalr_pkg::FREQ_W) - 1);
            endcase
            thr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, 130) - 10;
            avg = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, 130) - 10;
            ucl = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, 140);
            case ($urandom_range(0, 9))
                0:          rng = 0;
                1:          rng = -$urandom_range(1, 256);
                2, 3, 4:    rng = $urandom_range(0, (1 << nalr_pkg::RANGE_W) - 1);
                default:    rng = $urandom_range(1, 150);
            endcase
            gap = 0;
            if (bursty && i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 17);
            end
            queue_band(f, thr, avg, ucl, rng, gap);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bands_sent != bands_total || prescription_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/nalr_pkg.sv
hw/rtl/nal_r_band_gain_prescriber.sv
verif/nal_r_band_gain_prescriber_tb.sv
